FILE: hw/rtl/bcd_pkg.sv
package bcd_pkg;

  // Phase codes double as event codes (0 means no event).
  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_DOWN   = 3'd1,
    PH_UP     = 3'd2,
    PH_REPEAT = 3'd3,
    PH_SINGLE = 3'd4,
    PH_DOUBLE = 3'd5,
    PH_TRIPLE = 3'd6,
    PH_LONG   = 3'd7
  } phase_t;

  typedef enum logic [2:0] {
    REG_PRESSED_LEVEL = 3'd0,
    REG_DEBOUNCE      = 3'd1,
    REG_LONG          = 3'd2,
    REG_SHORT         = 3'd3,
    REG_ENABLE        = 3'd4
  } reg_idx_t;

  localparam int unsigned DEB_W   = 9;
  localparam int unsigned TICK_W  = 17;
  localparam int unsigned TALLY_W = 8;

  localparam logic [DEB_W-1:0]   DEB_MAX   = '1;
  localparam logic [TICK_W-1:0]  TICK_MAX  = '1;
  localparam logic [TALLY_W-1:0] TALLY_MAX = '1;

  typedef struct packed {
    logic        pressed_level;
    logic [7:0]  debounce_ticks;
    logic [15:0] long_ticks;
    logic [7:0]  short_ticks;
    logic [6:0]  event_enable;
  } cfg_t;

  typedef struct packed {
    phase_t              phase;
    logic [DEB_W-1:0]    debounce_count;
    logic [TICK_W-1:0]   tick_count;
    logic [TALLY_W-1:0]  click_tally;
    logic                press_active;
  } state_t;

  typedef struct packed {
    logic [2:0] event_code;
    logic [7:0] click_count;
    logic [2:0] detector_phase;
  } result_t;

endpackage

FILE: hw/rtl/bcd_apb_regs.sv
module bcd_apb_regs (
  input  logic          clk,
  input  logic          rst,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [4:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready,
  output bcd_pkg::cfg_t cfg
);
  import bcd_pkg::*;

  reg_idx_t idx;
  logic     wr_en;

  assign pready = 1'b1;
  assign idx    = reg_idx_t'(paddr[4:2]);
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wr_en) begin
      unique case (idx)
        REG_PRESSED_LEVEL: cfg.pressed_level  <= pwdata[0];
        REG_DEBOUNCE:      cfg.debounce_ticks <= pwdata[7:0];
        REG_LONG:          cfg.long_ticks     <= pwdata[15:0];
        REG_SHORT:         cfg.short_ticks    <= pwdata[7:0];
        REG_ENABLE:        cfg.event_enable   <= pwdata[6:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_PRESSED_LEVEL: prdata = {31'd0, cfg.pressed_level};
      REG_DEBOUNCE:      prdata = {24'd0, cfg.debounce_ticks};
      REG_LONG:          prdata = {16'd0, cfg.long_ticks};
      REG_SHORT:         prdata = {24'd0, cfg.short_ticks};
      REG_ENABLE:        prdata = {25'd0, cfg.event_enable};
      default:           prdata = '0;
    endcase
  end

endmodule

FILE: hw/rtl/bcd_step.sv
module bcd_step (
  input  logic            key_level,
  input  bcd_pkg::cfg_t   cfg,
  input  bcd_pkg::state_t st,
  output bcd_pkg::state_t st_next,
  output bcd_pkg::result_t res
);
  import bcd_pkg::*;

  logic              pressed;
  phase_t            ph;
  phase_t            ev;
  logic [TICK_W-1:0] tick_inc;
  logic [2:0]        en_idx;

  always_comb begin
    st_next  = st;
    ev       = PH_IDLE;
    pressed  = (key_level == cfg.pressed_level);
    ph       = st.phase;
    tick_inc = (st.tick_count == TICK_MAX) ? st.tick_count : st.tick_count + 1'b1;

    // debounce; an accepted press overrides whatever phase we were in
    if (pressed && !st.press_active) begin
      st_next.debounce_count = (st.debounce_count == DEB_MAX) ?
                               st.debounce_count : st.debounce_count + 1'b1;
      if (st.debounce_count > {1'b0, cfg.debounce_ticks}) begin
        ph                     = PH_DOWN;
        st_next.press_active   = 1'b1;
        st_next.debounce_count = '0;
      end
    end else begin
      st_next.debounce_count = '0;
    end

    st_next.phase = ph;

    unique case (ph)
      PH_IDLE: begin
        st_next.press_active = 1'b0;
        st_next.click_tally  = '0;
      end
      PH_DOWN: begin
        if (pressed) begin
          ev                 = PH_DOWN;
          st_next.tick_count = tick_inc;
          if (st.tick_count > {1'b0, cfg.long_ticks}) st_next.phase = PH_LONG;
        end else begin
          st_next.phase = PH_UP;
        end
      end
      PH_UP: begin
        if (st.tick_count > {9'd0, cfg.short_ticks}) begin
          ev                 = PH_UP;
          st_next.phase      = PH_IDLE;
          st_next.tick_count = '0;
        end else begin
          st_next.phase      = PH_REPEAT;
          st_next.tick_count = tick_inc;
        end
      end
      PH_REPEAT: begin
        st_next.tick_count = tick_inc;
        if (st.tick_count < {9'd0, cfg.short_ticks}) begin
          if (st_next.press_active && st.click_tally != TALLY_MAX)
            st_next.click_tally = st.click_tally + 1'b1;
        end else if (st.click_tally == 8'd1) begin
          st_next.phase = PH_SINGLE;
        end else if (st.click_tally == 8'd2) begin
          st_next.phase = PH_DOUBLE;
        end else if (st.click_tally == 8'd3) begin
          st_next.phase = PH_TRIPLE;
        end else begin
          ev            = PH_REPEAT;
          st_next.phase = PH_IDLE;
        end
        st_next.press_active = 1'b0;
      end
      PH_SINGLE, PH_DOUBLE, PH_TRIPLE: begin
        ev                 = ph;
        st_next.phase      = PH_IDLE;
        st_next.tick_count = '0;
      end
      default: begin // long press: rearm at the short window
        ev                   = PH_LONG;
        st_next.phase        = PH_IDLE;
        st_next.press_active = 1'b1;
        st_next.tick_count   = {9'd0, cfg.short_ticks};
      end
    endcase

    en_idx             = ev - 3'd1;
    res.event_code     = '0;
    res.click_count    = '0;
    res.detector_phase = st_next.phase;
    if (ev != PH_IDLE && cfg.event_enable[en_idx]) begin
      res.event_code = ev;
      if (ev == PH_REPEAT || ev == PH_SINGLE || ev == PH_DOUBLE || ev == PH_TRIPLE)
        res.click_count = st_next.click_tally;
    end
  end

endmodule

FILE: hw/rtl/button_click_detector_core.sv
// A beat goes to the input register, then to the state and result registers;
// an output stall holds it in the input register. Next state is combinational.
// Throughput: one beat per cycle while the output is not stalled.
// Reset (rst, synchronous, active high): phase idle, all counters and configuration
// registers zero, no beat held in either stage.
module button_click_detector_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        key_level,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  event_code,
  output logic [7:0]  click_count,
  output logic [2:0]  detector_phase,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import bcd_pkg::*;

  cfg_t    cfg;
  state_t  st;
  state_t  st_next;
  result_t res;
  logic    s1_valid;
  logic    key_q;
  logic    adv;

  bcd_apb_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  bcd_step u_step (
    .key_level (key_q),
    .cfg       (cfg),
    .st        (st),
    .st_next   (st_next),
    .res       (res)
  );

  assign adv      = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
      st        <= '{PH_IDLE, '0, '0, '0, 1'b0};
    end else begin
      if (in_valid && in_ready) begin
        s1_valid <= 1'b1;
      end else if (adv) begin
        s1_valid <= 1'b0;
      end
      if (adv) begin
        out_valid <= 1'b1;
        st        <= st_next;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) key_q <= key_level;
    if (adv) begin
      event_code     <= res.event_code;
      click_count    <= res.click_count;
      detector_phase <= res.detector_phase;
    end
  end

  a_event_enabled: assert property (@(posedge clk) disable iff (rst)
    out_valid && event_code != PH_IDLE |-> cfg.event_enable[event_code - 3'd1])
    else $error("reported event is not enabled");

  a_count_only_clicks: assert property (@(posedge clk) disable iff (rst)
    out_valid && click_count != 8'd0 |->
      (event_code == PH_REPEAT || event_code == PH_SINGLE ||
       event_code == PH_DOUBLE || event_code == PH_TRIPLE))
    else $error("click count on a non-click event");

  a_long_to_idle: assert property (@(posedge clk) disable iff (rst)
    out_valid && event_code == PH_LONG |-> detector_phase == PH_IDLE)
    else $error("long press did not return to idle");

  a_click_phase_exit: assert property (@(posedge clk) disable iff (rst)
    adv && (st.phase == PH_SINGLE || st.phase == PH_DOUBLE || st.phase == PH_TRIPLE) &&
    st.press_active == 1'b0 && !(key_q == cfg.pressed_level)
      |=> st.phase == PH_IDLE)
    else $error("click report phase did not exit");

endmodule
